// File: src/touch_slider_centroid_core_macros.svh
// Assertion macros shared by the checker of the slider centroid core.
`ifndef TOUCH_SLIDER_CENTROID_CORE_MACROS_SVH
`define TOUCH_SLIDER_CENTROID_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/tsc_pkg.sv
// Shared widths, register indexes and control types of the slider centroid core.
package tsc_pkg;

	localparam int CONV_W        = 16;
	localparam int THR_W         = 16;
	localparam int STEP_W        = 12;
	localparam int MUL_W         = 16;
	localparam int PROD_W        = 2 * MUL_W;
	localparam int RSUM_W        = 20;
	localparam int WSUM_W        = 36;
	localparam int POS_W         = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;
	localparam int PAD_COUNT_DEF = 12;

	localparam logic [CFG_IDX_W-1:0] REG_ACT_THRESHOLD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BIN_STEP      = CFG_IDX_W'(1);

	typedef struct packed {
		logic load;        // latch the pad response
		logic mul_weight;  // pad index times bin step
		logic mul_prod;    // response times weight
		logic accumulate;  // fold product and response into the sums
		logic clear;       // start a new scan
	} tsc_acc_ctl_t;

	typedef struct packed {
		logic [RSUM_W-1:0] response_sum;
		logic [WSUM_W-1:0] weighted_sum;
		logic              touched;
	} tsc_acc_stat_t;

endpackage

// File: src/tsc_if.sv
// Channel interfaces of the slider centroid core: pad beats, position beats, register writes.
interface tsc_pad_if import tsc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CONV_W-1:0] conversion_result;
	logic [CONV_W-1:0] ambient_level;
	logic              last_pad;

	modport source (output valid, conversion_result, ambient_level, last_pad, input ready);
	modport sink (input valid, conversion_result, ambient_level, last_pad, output ready);
endinterface

interface tsc_pos_if import tsc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] slider_position;
	logic             touched;

	modport source (output valid, slider_position, touched, input ready);
	modport sink (input valid, slider_position, touched, output ready);
endinterface

interface tsc_cfg_if import tsc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: src/tsc_acc.sv
// Scan accumulator around one shared 16x16 multiplier.
module tsc_acc import tsc_pkg::*; #(
	parameter int PAD_COUNT = PAD_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tsc_acc_ctl_t      ctl,
	input  logic [CONV_W-1:0] conversion_result,
	input  logic [CONV_W-1:0] ambient_level,
	input  logic [THR_W-1:0]  threshold,
	input  logic [STEP_W-1:0] bin_step,
	output tsc_acc_stat_t     stat
);

	localparam int PAD_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
	localparam logic [PAD_W-1:0] PAD_LAST = PAD_W'(PAD_COUNT - 1);

	logic [PAD_W-1:0]  pad_q;
	logic [CONV_W-1:0] resp_q;
	logic [PROD_W-1:0] mul_q;
	logic [RSUM_W-1:0] rsum_q;
	logic [WSUM_W-1:0] wsum_q;
	logic              seen_q;

	logic [MUL_W-1:0]  mul_a;
	logic [MUL_W-1:0]  mul_b;
	logic [RSUM_W:0]   rsum_add;
	logic [WSUM_W:0]   wsum_add;

	// One multiplier: first index by step, then response by weight.
	always_comb begin
		if (ctl.mul_prod) begin
			mul_a = MUL_W'(resp_q);
			mul_b = mul_q[MUL_W-1:0];
		end else begin
			mul_a = MUL_W'(pad_q);
			mul_b = MUL_W'(bin_step);
		end
	end

	assign rsum_add = {1'b0, rsum_q} + (RSUM_W+1)'(resp_q);
	assign wsum_add = {1'b0, wsum_q} + (WSUM_W+1)'(mul_q);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			resp_q <= (conversion_result > ambient_level) ?
				conversion_result - ambient_level : '0;
		end
		if (ctl.mul_weight || ctl.mul_prod) begin
			mul_q <= mul_a * mul_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q  <= '0;
			rsum_q <= '0;
			wsum_q <= '0;
			seen_q <= 1'b0;
		end else if (ctl.clear) begin
			pad_q  <= '0;
			rsum_q <= '0;
			wsum_q <= '0;
			seen_q <= 1'b0;
		end else if (ctl.accumulate) begin
			rsum_q <= rsum_add[RSUM_W] ? '1 : rsum_add[RSUM_W-1:0];
			wsum_q <= wsum_add[WSUM_W] ? '1 : wsum_add[WSUM_W-1:0];
			if (resp_q > threshold) begin
				seen_q <= 1'b1;
			end
			// Extra pads of an overlong scan weigh as the last pad.
			if (pad_q != PAD_LAST) begin
				pad_q <= pad_q + PAD_W'(1);
			end
		end
	end

	assign stat.response_sum = rsum_q;
	assign stat.weighted_sum = wsum_q;
	assign stat.touched      = seen_q;

endmodule

// File: src/tsc_div.sv
// Restoring divider, one quotient bit per cycle, result saturated to the position width.
module tsc_div import tsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              ack,
	input  logic [WSUM_W-1:0] dividend,
	input  logic [RSUM_W-1:0] divisor,
	output logic              done,
	output logic [POS_W-1:0]  quotient
);

	localparam int STEPS = WSUM_W;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [RSUM_W-1:0] rem_q;
	logic [WSUM_W-1:0] quo_q;
	logic [RSUM_W-1:0] dsr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [RSUM_W:0]   shifted;
	logic [RSUM_W+1:0] diff;
	logic              ge;

	assign shifted = {rem_q, quo_q[WSUM_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dsr_q};
	assign ge      = !diff[RSUM_W+1];

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[RSUM_W-1:0] : shifted[RSUM_W-1:0];
			quo_q <= {quo_q[WSUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(STEPS - 1);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else if (ack) begin
			done_q <= 1'b0;
		end
	end

	assign done     = done_q;
	assign quotient = (|quo_q[WSUM_W-1:POS_W]) ? '1 : quo_q[POS_W-1:0];

endmodule

// File: src/touch_slider_centroid_core.sv
// Slider centroid core: takes one pad beat at a time, accumulates
// the response and index-weighted response of a scan with one shared multiplier,
// and on the last pad of a touched scan divides the two sums bit-serially into
// a position. A pad beat occupies the core through its steps (response, weight
// multiply, product multiply, accumulate); pad.ready is low meanwhile. The last
// pad of an untouched scan adds a finish state; the last pad of a touched scan
// adds the finish state and then the divide state, in which a restoring divide
// of the 36-bit weighted sum yields one quotient bit per cycle. A finished
// position waits in an output register while the next scan begins; the core
// stalls only if a further position is ready before the previous one is taken.
// Register writes are always accepted; unknown indexes are ignored.
module touch_slider_centroid_core import tsc_pkg::*; #(
	parameter int PAD_COUNT = PAD_COUNT_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	tsc_pad_if.sink   pad,
	tsc_pos_if.source position,
	tsc_cfg_if.sink   cfg
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_WEIGHT = 6'b000010,
		S_PROD   = 6'b000100,
		S_ACC    = 6'b001000,
		S_FIN    = 6'b010000,
		S_DIV    = 6'b100000
	} state_t;

	state_t            state_q;
	state_t            state_d;
	logic              last_q;
	logic [THR_W-1:0]  thr_q;
	logic [STEP_W-1:0] bin_q;
	logic              out_valid_q;
	logic [POS_W-1:0]  out_pos_q;
	logic              out_touched_q;

	tsc_acc_ctl_t      ctl;
	tsc_acc_stat_t     stat;
	logic              pad_beat;
	logic              out_free;
	logic              div_start;
	logic              div_ack;
	logic              div_done;
	logic [POS_W-1:0]  div_quo;
	logic              out_load;
	logic [POS_W-1:0]  out_pos_d;
	logic              out_touched_d;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
			bin_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ACT_THRESHOLD: thr_q <= THR_W'(cfg.data);
				REG_BIN_STEP:      bin_q <= cfg.data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	assign pad.ready = (state_q == S_IDLE);
	assign pad_beat  = pad.valid && pad.ready;
	assign out_free  = !out_valid_q || position.ready;

	always_comb begin
		state_d        = state_q;
		ctl            = '0;
		div_start      = 1'b0;
		div_ack        = 1'b0;
		out_load       = 1'b0;
		out_pos_d      = '0;
		out_touched_d  = 1'b0;
		ctl.load       = pad_beat;
		unique case (state_q)
			S_IDLE: begin
				if (pad_beat) begin
					state_d = S_WEIGHT;
				end
			end
			S_WEIGHT: begin
				ctl.mul_weight = 1'b1;
				state_d        = S_PROD;
			end
			S_PROD: begin
				ctl.mul_prod = 1'b1;
				state_d      = S_ACC;
			end
			S_ACC: begin
				ctl.accumulate = 1'b1;
				state_d        = last_q ? S_FIN : S_IDLE;
			end
			S_FIN: begin
				// Divide only when touched; an empty sum gives position zero.
				if (stat.touched && (stat.response_sum != '0)) begin
					div_start = 1'b1;
					ctl.clear = 1'b1;
					state_d   = S_DIV;
				end else if (out_free) begin
					out_load      = 1'b1;
					out_touched_d = stat.touched;
					ctl.clear     = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_DIV: begin
				if (div_done && out_free) begin
					out_load      = 1'b1;
					out_pos_d     = div_quo;
					out_touched_d = 1'b1;
					div_ack       = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (position.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pad_beat) begin
			last_q <= pad.last_pad;
		end
		if (out_load) begin
			out_pos_q     <= out_pos_d;
			out_touched_q <= out_touched_d;
		end
	end

	assign position.valid           = out_valid_q;
	assign position.slider_position = out_pos_q;
	assign position.touched         = out_touched_q;

	tsc_acc #(
		.PAD_COUNT(PAD_COUNT)
	) u_acc (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctl               (ctl),
		.conversion_result (pad.conversion_result),
		.ambient_level     (pad.ambient_level),
		.threshold         (thr_q),
		.bin_step          (bin_q),
		.stat              (stat)
	);

	tsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.ack      (div_ack),
		.dividend (stat.weighted_sum),
		.divisor  (stat.response_sum),
		.done     (div_done),
		.quotient (div_quo)
	);

endmodule

// File: src/tsc_checker.sv
// Port-level checker of the slider centroid core and its bind.
`include "touch_slider_centroid_core_macros.svh"

module tsc_checker import tsc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             pad_valid,
	input logic             pad_ready,
	input logic             pos_valid,
	input logic             pos_ready,
	input logic [POS_W-1:0] pos_slider_position,
	input logic             pos_touched
);

	`TSC_ASSERT_NEXT(a_pos_hold, pos_valid && !pos_ready, pos_valid, "position beat dropped while stalled")
	`TSC_ASSERT_NEXT(a_pos_stable, pos_valid && !pos_ready, $stable(pos_slider_position), "stalled position changed")
	`TSC_ASSERT_SAME(a_untouched_zero, pos_valid && !pos_touched, pos_slider_position == '0, "untouched scan with nonzero position")
	`TSC_ASSERT_NEXT(a_pad_busy, pad_valid && pad_ready, !pad_ready, "pad beat taken while previous pad in work")

endmodule

bind touch_slider_centroid_core tsc_checker u_tsc_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.pad_valid           (pad.valid),
	.pad_ready           (pad.ready),
	.pos_valid           (position.valid),
	.pos_ready           (position.ready),
	.pos_slider_position (position.slider_position),
	.pos_touched         (position.touched)
);
